// File: src/pcts_pkg.sv
// ----------------------------------------------------------------------------
// pcts_pkg: shared types and constants for the pseudocode token scanner
// Item structs, token kind codes, scan modes and the keyword table.
// ----------------------------------------------------------------------------
`default_nettype none

package pcts_pkg;

    localparam int POS_BITS    = 24;
    localparam int WORD_MAX    = 11;
    localparam int WORD_IDX_W  = $clog2(WORD_MAX);
    localparam int KW_COUNT    = 24;
    localparam int KW_IDX_W    = $clog2(KW_COUNT + 1);
    localparam int KIND_W      = 4;

    localparam logic [POS_BITS-1:0] POS_MAX    = {POS_BITS{1'b1}};
    localparam logic [KW_IDX_W-1:0] NO_KEYWORD = KW_IDX_W'(KW_COUNT);
    localparam logic [KW_IDX_W-1:0] KW_TRUE    = KW_IDX_W'(18);
    localparam logic [KW_IDX_W-1:0] KW_FALSE   = KW_IDX_W'(19);

    // Token kind codes
    localparam logic [KIND_W-1:0] KIND_KEYWORD    = 4'd0;
    localparam logic [KIND_W-1:0] KIND_BOOLEAN    = 4'd1;
    localparam logic [KIND_W-1:0] KIND_IDENTIFIER = 4'd2;
    localparam logic [KIND_W-1:0] KIND_INTEGER    = 4'd3;
    localparam logic [KIND_W-1:0] KIND_FLOAT      = 4'd4;
    localparam logic [KIND_W-1:0] KIND_STRING     = 4'd5;
    localparam logic [KIND_W-1:0] KIND_SEPARATOR  = 4'd6;
    localparam logic [KIND_W-1:0] KIND_OPERATOR   = 4'd7;
    localparam logic [KIND_W-1:0] KIND_ASSIGN     = 4'd8;
    localparam logic [KIND_W-1:0] KIND_END        = 4'd9;

    // Keywords in table order; text is right-aligned, first char highest
    localparam logic [WORD_MAX*8-1:0] KW_TEXT [KW_COUNT] = '{
        "START", "END", "ARRAY", "STRUCT", "IF", "THEN", "ELSE", "ENDIF",
        "WHILE", "ENDWHILE", "FOR", "ENDFOR", "DO", "TO", "FUNCTION",
        "ENDFUNCTION", "RETURN", "PRINT", "TRUE", "FALSE", "AND", "OR", "NOT", "READ"
    };
    localparam int KW_LEN [KW_COUNT] = '{
        5, 3, 5, 6, 2, 4, 4, 5, 5, 8, 3, 6, 2, 2, 8, 11, 6, 5, 4, 5, 3, 2, 3, 4
    };

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_INT,
        MODE_FLOAT,
        MODE_WORD,
        MODE_STR,
        MODE_EQ,
        MODE_CMP
    } scan_mode_t;

    typedef logic [WORD_MAX-1:0][7:0] word_buf_t;

    typedef struct packed {
        logic       action;
        logic [7:0] ch;
    } in_item_t;

    typedef struct packed {
        logic [KIND_W-1:0]   token_kind;
        logic [POS_BITS-1:0] start_offset;
        logic [POS_BITS-1:0] token_length;
        logic [KW_IDX_W-1:0] keyword_number;
        logic                unterminated;
        logic                last_in_run;
    } out_item_t;

    // Results of one processed item, in order
    typedef struct packed {
        logic [1:0] cnt;
        out_item_t  first;
        out_item_t  second;
    } result_pair_t;

    function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
        return (v == POS_MAX) ? v : v + 1'b1;
    endfunction

endpackage

`default_nettype wire

// File: src/pseudocode_token_scanner_unit.sv
// ----------------------------------------------------------------------------
// pseudocode_token_scanner_unit: streaming pseudocode lexer
// Bytes in, token descriptors (kind, offset, length, keyword) out.
// ----------------------------------------------------------------------------
// Path: an accepted item waits in the input register, is scanned once the
//   result queue has room, and its tokens are read from the queue head.
// Throughput: one item per cycle while items yield at most one token each
//   and the queue has room; the result queue hands out one token per cycle
//   while out_ready is high, so the two tokens of one item leave in turn.
// Reset: rst_n (async, low) clears scan state, the input register and the queue.
`default_nettype none

module pseudocode_token_scanner_unit
    import pcts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    // Input register: holds one item until the queue has room for
    // everything it may produce (two tokens at most).
    logic         in_valid_reg, in_valid_next;
    in_item_t     in_item_reg;
    logic         step;
    logic         room;
    result_pair_t results;

    assign step     = in_valid_reg && room;
    assign in_ready = !in_valid_reg || step;

    always_comb
    begin
        if (in_valid && in_ready)
            in_valid_next = 1'b1;
        else if (step)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_item_reg <= in_item;
    end

    // Scanner: mode update, keyword compare, token build in one pass
    pcts_scan_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .item    (in_item_reg),
        .results (results)
    );

    // Result queue decouples two-token items from the output side
    pcts_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (step),
        .push_data (results),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule

`default_nettype wire

// File: src/pcts_keyword_match.sv
// ----------------------------------------------------------------------------
// pcts_keyword_match: keyword lookup
// Compares the buffered word against all keywords in parallel.
// ----------------------------------------------------------------------------
`default_nettype none

module pcts_keyword_match
    import pcts_pkg::*;
(
    input  word_buf_t             word_buf,
    input  logic [POS_BITS-1:0]   word_len,
    output logic                  kw_hit,
    output logic [KW_IDX_W-1:0]   kw_index
);

    always_comb
    begin
        logic eq;
        int   sel;
        kw_hit   = 1'b0;
        kw_index = NO_KEYWORD;
        // lowest index wins; keywords are distinct anyway
        for (int i = KW_COUNT - 1; i >= 0; i--)
        begin
            eq = (word_len == POS_BITS'(KW_LEN[i]));
            for (int j = 0; j < WORD_MAX; j++)
            begin
                sel = (j < KW_LEN[i]) ? (KW_LEN[i] - 1 - j) : 0;
                if (j < KW_LEN[i] && word_buf[j] != KW_TEXT[i][sel*8 +: 8])
                begin
                    eq = 1'b0;
                end
            end
            if (eq)
            begin
                kw_hit   = 1'b1;
                kw_index = KW_IDX_W'(i);
            end
        end
    end

endmodule

`default_nettype wire

// File: src/pcts_scan_core.sv
// ----------------------------------------------------------------------------
// pcts_scan_core: per-byte scanner state machine
// Updates the scan mode and token bookkeeping, emits up to two tokens per item.
// ----------------------------------------------------------------------------
`default_nettype none

module pcts_scan_core
    import pcts_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step,
    input  in_item_t     item,
    output result_pair_t results
);

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    scan_mode_t          mode_reg, mode_next;
    logic [POS_BITS-1:0] start_reg, start_next;
    logic [POS_BITS-1:0] count_reg, count_next;
    logic [POS_BITS-1:0] pos_reg, pos_next;
    logic                ended_reg, ended_next;
    word_buf_t           buf_reg, buf_next;

    logic                kw_hit;
    logic [KW_IDX_W-1:0] kw_index;
    out_item_t           flush_item;
    logic                a_valid, b_valid;
    out_item_t           a_item, b_item;

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return (c >= 8'h21 && c <= 8'h2F) || (c >= 8'h3A && c <= 8'h40) ||
               (c >= 8'h5B && c <= 8'h60) || (c >= 8'h7B && c <= 8'h7E);
    endfunction

    function automatic logic is_sep(input logic [7:0] c);
        return c == 8'h2C || c == 8'h3B || c == 8'h28 || c == 8'h29 ||
               c == 8'h7B || c == 8'h7D || c == 8'h5B || c == 8'h5D;
    endfunction

    function automatic out_item_t make_item(
        input logic [KIND_W-1:0]   kind,
        input logic [POS_BITS-1:0] start,
        input logic [POS_BITS-1:0] len,
        input logic [KW_IDX_W-1:0] kw,
        input logic                unterm
    );
        out_item_t r;
        r.token_kind     = kind;
        r.start_offset   = start;
        r.token_length   = len;
        r.keyword_number = kw;
        r.unterminated   = unterm;
        r.last_in_run    = 1'b0;
        return r;
    endfunction

    pcts_keyword_match u_kw (
        .word_buf (buf_reg),
        .word_len (count_reg),
        .kw_hit   (kw_hit),
        .kw_index (kw_index)
    );

    // Token that closes when the open one is cut short
    always_comb
    begin
        unique case (mode_reg)
            MODE_INT:
                flush_item = make_item(KIND_INTEGER, start_reg, count_reg, NO_KEYWORD, 1'b0);
            MODE_FLOAT:
                flush_item = make_item(KIND_FLOAT, start_reg, count_reg, NO_KEYWORD, 1'b0);
            MODE_WORD:
                if (kw_hit)
                    flush_item = make_item(
                        (kw_index == KW_TRUE || kw_index == KW_FALSE) ? KIND_BOOLEAN
                                                                      : KIND_KEYWORD,
                        start_reg, count_reg, kw_index, 1'b0);
                else
                    flush_item = make_item(KIND_IDENTIFIER, start_reg, count_reg,
                                           NO_KEYWORD, 1'b0);
            MODE_STR:
                flush_item = make_item(KIND_STRING, start_reg, count_reg, NO_KEYWORD, 1'b1);
            MODE_EQ:
                flush_item = make_item(KIND_ASSIGN, start_reg, POS_BITS'(1), NO_KEYWORD, 1'b0);
            MODE_CMP:
                flush_item = make_item(KIND_OPERATOR, start_reg, POS_BITS'(1), NO_KEYWORD,
                                       1'b0);
            default:
                flush_item = '0;
        endcase
    end

    always_comb
    begin
        logic [7:0] c;
        logic       pass;
        c          = item.ch;
        pass       = 1'b0;
        mode_next  = mode_reg;
        start_next = start_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        ended_next = ended_reg;
        buf_next   = buf_reg;
        a_valid    = 1'b0;
        a_item     = flush_item;
        b_valid    = 1'b0;
        b_item     = '0;

        if (step)
        begin
            if (item.action)
            begin
                // close open token, then end token, then start over
                a_valid    = (mode_reg != MODE_IDLE);
                b_valid    = 1'b1;
                b_item     = make_item(KIND_END, pos_reg, '0, NO_KEYWORD, 1'b0);
                mode_next  = MODE_IDLE;
                start_next = '0;
                count_next = '0;
                pos_next   = '0;
                ended_next = 1'b0;
            end
            else if (!ended_reg)
            begin
                unique case (mode_reg) inside
                    MODE_INT, MODE_FLOAT:
                    begin
                        if (is_digit(c) || (c == CH_DOT && mode_reg == MODE_INT))
                        begin
                            if (c == CH_DOT)
                                mode_next = MODE_FLOAT;
                            count_next = sat_inc(count_reg);
                        end
                        else
                        begin
                            a_valid   = 1'b1;
                            mode_next = MODE_IDLE;
                            pass      = 1'b1;
                        end
                    end
                    MODE_WORD:
                    begin
                        if (is_digit(c) || is_alpha(c) || c == CH_UNDER)
                        begin
                            if (count_reg < POS_BITS'(WORD_MAX))
                                buf_next[count_reg[WORD_IDX_W-1:0]] = c;
                            count_next = sat_inc(count_reg);
                        end
                        else
                        begin
                            a_valid   = 1'b1;
                            mode_next = MODE_IDLE;
                            pass      = 1'b1;
                        end
                    end
                    MODE_STR:
                    begin
                        if (c == CH_QUOTE)
                        begin
                            a_valid   = 1'b1;
                            a_item    = make_item(KIND_STRING, start_reg, count_reg,
                                                  NO_KEYWORD, 1'b0);
                            mode_next = MODE_IDLE;
                        end
                        else if (c == CH_NUL)
                        begin
                            a_valid   = 1'b1;
                            mode_next = MODE_IDLE;
                            pass      = 1'b1;
                        end
                        else
                        begin
                            count_next = sat_inc(count_reg);
                        end
                    end
                    MODE_EQ, MODE_CMP:
                    begin
                        a_valid   = 1'b1;
                        mode_next = MODE_IDLE;
                        if (c == CH_EQ)
                            a_item = make_item(KIND_OPERATOR, start_reg, POS_BITS'(2),
                                               NO_KEYWORD, 1'b0);
                        else
                            pass = 1'b1;
                    end
                    default:
                    begin
                        mode_next = MODE_IDLE;
                        pass      = 1'b1;
                    end
                endcase

                // byte seen between tokens
                if (pass)
                begin
                    if (c == CH_NUL)
                    begin
                        ended_next = 1'b1;
                    end
                    else if (!is_space(c))
                    begin
                        start_next = pos_reg;
                        count_next = POS_BITS'(1);
                        if (is_digit(c))
                        begin
                            mode_next = MODE_INT;
                        end
                        else if (is_alpha(c))
                        begin
                            mode_next   = MODE_WORD;
                            buf_next[0] = c;
                        end
                        else if (c == CH_QUOTE)
                        begin
                            mode_next  = MODE_STR;
                            start_next = sat_inc(pos_reg);
                            count_next = '0;
                        end
                        else if (is_sep(c))
                        begin
                            b_valid = 1'b1;
                            b_item  = make_item(KIND_SEPARATOR, pos_reg, POS_BITS'(1),
                                                NO_KEYWORD, 1'b0);
                        end
                        else if (c == CH_EQ)
                        begin
                            mode_next = MODE_EQ;
                        end
                        else if (c == CH_BANG || c == CH_LT || c == CH_GT)
                        begin
                            mode_next = MODE_CMP;
                        end
                        else if (is_punct(c))
                        begin
                            b_valid = 1'b1;
                            b_item  = make_item(KIND_OPERATOR, pos_reg, POS_BITS'(1),
                                                NO_KEYWORD, 1'b0);
                        end
                    end
                end

                if (!ended_next)
                    pos_next = sat_inc(pos_reg);
            end
        end
    end

    // Pack results in order, flag the last one
    always_comb
    begin
        results.cnt    = {1'b0, a_valid} + {1'b0, b_valid};
        results.first  = a_valid ? a_item : b_item;
        results.second = b_item;
        if (a_valid && b_valid)
            results.second.last_in_run = 1'b1;
        else
            results.first.last_in_run = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            start_reg <= '0;
            count_reg <= '0;
            pos_reg   <= '0;
            ended_reg <= 1'b0;
        end
        else
        begin
            mode_reg  <= mode_next;
            start_reg <= start_next;
            count_reg <= count_next;
            pos_reg   <= pos_next;
            ended_reg <= ended_next;
        end
    end

    // word buffer holds data only; never read before written
    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

    a_ended_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ended_reg |-> (mode_reg == MODE_IDLE))
        else $error("scanner open token after text end");

    a_end_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (step && item.action) |=> (pos_reg == '0 && !ended_reg && mode_reg == MODE_IDLE))
        else $error("end of text did not restart scanner");

    a_end_token_last: assert property (@(posedge clk) disable iff (!rst_n)
        (step && item.action) |->
            ((results.cnt == 2'd1 && results.first.token_kind == KIND_END) ||
             (results.cnt == 2'd2 && results.second.token_kind == KIND_END)))
        else $error("end of text without final end token");

endmodule

`default_nettype wire

// File: src/pcts_result_fifo.sv
// ----------------------------------------------------------------------------
// pcts_result_fifo: token result queue
// Takes up to two results per cycle when it has room, hands out one per ready cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pcts_result_fifo
    import pcts_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  result_pair_t push_data,
    output logic         room,
    output logic         out_valid,
    input  logic         out_ready,
    output out_item_t    out_item
);

    localparam int DEPTH  = 4;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    out_item_t          entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [1:0]         n_push;
    logic               pop;

    assign n_push    = push ? push_data.cnt : 2'd0;
    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != '0);
    assign out_item  = entry_reg[rd_ptr_reg];
    // room for a two-result item
    assign room      = (count_reg <= CNT_W'(DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(n_push);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(n_push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
            entry_reg[wr_ptr_reg] <= push_data.first;
        if (n_push == 2'd2)
            entry_reg[wr_ptr_reg + PTR_W'(1)] <= push_data.second;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (n_push != 2'd0) |-> room)
        else $error("result queue written without room");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("result queue count out of range");

    a_head_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_item)))
        else $error("result queue head changed while waiting");

endmodule

`default_nettype wire
